/* hdl/ffba_pkg.sv */
// Package for the first-fit block allocator: sizes, status codes and the
// transaction and table-entry types. Used by the top level, the checkers and the testbench.
`default_nettype none
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W       = 21;
  localparam int START_W      = 20;
  localparam int SLOT_W       = 6;
  localparam int SUM_W        = SIZE_W + 2;
  localparam int CMP_W        = CNT_W + SLOT_W;

  localparam logic [SIZE_W-1:0] HEAP_CEILING = SIZE_W'(1048576);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_LIMIT  = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] req_size;
    logic [SLOT_W-1:0] block_index;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SIZE_W-1:0] payload_addr;
    logic [SLOT_W-1:0] slot;
  } out_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               is_free;
  } ent_t;

endpackage
`default_nettype wire

/* hdl/ffba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the block table for the allocator.
`default_nettype none
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/first_fit_block_allocator_unit.sv */
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-------------------------------------
// input     | start, busy, in_data         | taken when start is high, busy low
// result    | out_valid, out_data          | one-cycle strobe, cannot be stalled
// config    | cfg_valid, cfg_ready, cfg_data | written when valid and ready
//
// A zero-size allocate or a free with a bad index answers in the next cycle.
// A free reads its table entry once and answers from S_FREE. An allocate scans
// the table entries in order, up to block_count, and goes on to the append check
// in S_APPEND only if no free entry fits; the table RAM has a single read port.
// Reset clears block_count and heap_top and sets the limit to the heap ceiling;
// the table needs no clearing.
// The result side has no backpressure; busy alone throttles the input.
// Top level of the first-fit allocator; uses ffba_pkg and ffba_ram.
`default_nettype none
module first_fit_block_allocator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire ffba_pkg::in_t                in_data,
  output logic                              out_valid,
  output ffba_pkg::out_t                    out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ffba_pkg::SIZE_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_FREE
  } state_t;

  state_t                           state_r, state_nxt;
  ffba_pkg::in_t                    req_r, req_nxt;
  logic [ffba_pkg::IDX_W-1:0]       ptr_r, ptr_nxt;
  logic [ffba_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [ffba_pkg::SIZE_W-1:0]      top_r, top_nxt;
  logic [ffba_pkg::SIZE_W-1:0]      limit_r;
  logic                             out_valid_r, out_valid_nxt;
  ffba_pkg::out_t                   out_r, out_nxt;

  logic                             we;
  logic [ffba_pkg::IDX_W-1:0]       waddr;
  ffba_pkg::ent_t                   wdata;
  logic [ffba_pkg::IDX_W-1:0]       raddr;
  ffba_pkg::ent_t                   rdata;

  logic [ffba_pkg::SIZE_W-1:0]      eff_limit;
  logic [ffba_pkg::SUM_W-1:0]       new_top;
  logic                             last_scan;

  ffba_ram #(
    .WIDTH($bits(ffba_pkg::ent_t)),
    .DEPTH(ffba_pkg::MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign eff_limit = (limit_r > ffba_pkg::HEAP_CEILING) ? ffba_pkg::HEAP_CEILING : limit_r;
  assign new_top   = ffba_pkg::SUM_W'(top_r) + ffba_pkg::SUM_W'(ffba_pkg::HEADER_BYTES)
                     + ffba_pkg::SUM_W'(req_r.req_size);
  assign last_scan = (ffba_pkg::CNT_W'(ptr_r) + ffba_pkg::CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = ptr_r;
    wdata         = rdata;
    raddr         = ptr_r + ffba_pkg::IDX_W'(1);

    unique case (state_r)
      S_IDLE: begin
        raddr = (in_data.opcode == ffba_pkg::OP_FREE) ?
                ffba_pkg::IDX_W'(in_data.block_index) : '0;
        if (start) begin
          req_nxt = in_data;
          ptr_nxt = '0;
          if (in_data.opcode == ffba_pkg::OP_ALLOC) begin
            if (in_data.req_size == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ffba_pkg::ST_ZERO, payload_addr: '0, slot: '0};
            end else if (count_r == '0) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (ffba_pkg::CMP_W'(in_data.block_index) >= ffba_pkg::CMP_W'(count_r)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ffba_pkg::ST_BADIDX, payload_addr: '0,
                                slot: in_data.block_index};
            end else begin
              state_nxt = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        // The read data belongs to ptr_r; the read of the next entry is already issued.
        if (rdata.is_free && (rdata.size >= req_r.req_size)) begin
          we            = 1'b1;
          wdata.is_free = 1'b0;
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ffba_pkg::ST_OK,
                            payload_addr: ffba_pkg::SIZE_W'(rdata.start)
                                          + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES),
                            slot: ffba_pkg::SLOT_W'(ptr_r)};
          state_nxt     = S_IDLE;
        end else if (last_scan) begin
          state_nxt = S_APPEND;
        end else begin
          ptr_nxt = ptr_r + ffba_pkg::IDX_W'(1);
        end
      end

      S_APPEND: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (new_top > ffba_pkg::SUM_W'(eff_limit)) begin
          out_nxt = '{status: ffba_pkg::ST_LIMIT, payload_addr: '0, slot: '0};
        end else if (count_r == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) begin
          out_nxt = '{status: ffba_pkg::ST_FULL, payload_addr: '0, slot: '0};
        end else begin
          we        = 1'b1;
          waddr     = ffba_pkg::IDX_W'(count_r);
          wdata     = '{start: ffba_pkg::START_W'(top_r), size: req_r.req_size,
                        is_free: 1'b0};
          count_nxt = count_r + ffba_pkg::CNT_W'(1);
          top_nxt   = ffba_pkg::SIZE_W'(new_top);
          out_nxt   = '{status: ffba_pkg::ST_OK,
                        payload_addr: top_r + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES),
                        slot: ffba_pkg::SLOT_W'(count_r)};
        end
      end

      S_FREE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_nxt       = '{status: ffba_pkg::ST_OK, payload_addr: '0,
                          slot: req_r.block_index};
        if (ffba_pkg::CMP_W'(req_r.block_index) + ffba_pkg::CMP_W'(1)
            == ffba_pkg::CMP_W'(count_r)) begin
          // Freeing the last block releases it and pulls the heap top back.
          top_nxt   = ffba_pkg::SIZE_W'(rdata.start);
          count_nxt = ffba_pkg::CNT_W'(req_r.block_index);
        end else begin
          we            = 1'b1;
          waddr         = ffba_pkg::IDX_W'(req_r.block_index);
          wdata.is_free = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      top_r       <= '0;
      limit_r     <= ffba_pkg::HEAP_CEILING;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

/* hdl/ffba_chk.sv */
// Port-level checker for the first-fit allocator, bound to the top level.
// Depends on ffba_pkg for the status codes and transaction types.
`default_nettype none
module ffba_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire ffba_pkg::out_t out_data
);

  // Every accepted transaction either occupies the block or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor answered");

  a_no_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ffba_pkg::ST_BADIDX))
    else $error("result status outside the defined codes");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ffba_pkg::ST_OK)) |-> (out_data.payload_addr == '0))
    else $error("failed transaction carries a payload address");

endmodule

bind first_fit_block_allocator_unit ffba_chk u_ffba_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
`default_nettype wire

/* tb/ffba_checker.sv */
// Checker for the first-fit block allocator: watches the request, result and
// limit-write channels, predicts every result and compares it field by field.
// Depends on ffba_pkg for the transaction types, sizes and status codes.
module ffba_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  ffba_pkg::in_t                in_data,
  input  logic                         out_valid,
  input  ffba_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ffba_pkg::SIZE_W-1:0]  cfg_data,
  output int                           fail_count,
  output int                           n_pending,
  output int                           n_checked
);
  import ffba_pkg::*;

  // Shadow copy of the block table and heap bookkeeping.
  logic [START_W-1:0] tbl_start [MAX_BLOCKS];
  logic [SIZE_W-1:0]  tbl_size  [MAX_BLOCKS];
  logic               tbl_free  [MAX_BLOCKS];
  int unsigned        used_cnt;
  logic [SIZE_W-1:0]  top_addr;
  logic [SIZE_W-1:0]  limit_reg;

  out_t expected_q [$];

  function automatic out_t heap_step(in_t t);
    out_t             r;
    logic [SUM_W-1:0] grown;
    logic [SIZE_W-1:0] cap;
    int               hit;
    r = '0;
    hit = -1;
    if (t.opcode == OP_ALLOC) begin
      cap = (limit_reg > HEAP_CEILING) ? HEAP_CEILING : limit_reg;
      if (t.req_size == 0) begin
        r.status = ST_ZERO;
      end else begin
        for (int i = 0; i < used_cnt; i++) begin
          if (hit < 0 && tbl_free[i] && tbl_size[i] >= t.req_size) hit = i;
        end
        if (hit >= 0) begin
          // First fit: the whole block is handed out again, never split.
          tbl_free[hit] = 1'b0;
          r.status = ST_OK;
          r.payload_addr = SIZE_W'(tbl_start[hit] + HEADER_BYTES);
          r.slot = SLOT_W'(hit);
        end else begin
          grown = SUM_W'(top_addr + HEADER_BYTES + t.req_size);
          if (grown > cap) begin
            r.status = ST_LIMIT;
          end else if (used_cnt >= MAX_BLOCKS) begin
            r.status = ST_FULL;
          end else begin
            tbl_start[used_cnt] = top_addr[START_W-1:0];
            tbl_size[used_cnt]  = t.req_size;
            tbl_free[used_cnt]  = 1'b0;
            r.status = ST_OK;
            r.payload_addr = SIZE_W'(top_addr + HEADER_BYTES);
            r.slot = SLOT_W'(used_cnt);
            used_cnt++;
            top_addr = SIZE_W'(grown);
          end
        end
      end
    end else begin
      r.slot = t.block_index;
      if (t.block_index >= used_cnt) begin
        r.status = ST_BADIDX;
      end else begin
        r.status = ST_OK;
        // Releasing the topmost block gives its bytes back to the heap,
        // even when it was already marked free.
        if (t.block_index + 1 == used_cnt) begin
          top_addr = SIZE_W'(tbl_start[t.block_index]);
          used_cnt--;
        end else begin
          tbl_free[t.block_index] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      used_cnt = 0;
      top_addr = '0;
      limit_reg = HEAP_CEILING;
      expected_q.delete();
      fail_count = 0;
      n_checked = 0;
    end else begin
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        fail_count++;
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (start && !busy) expected_q.push_back(heap_step(in_data));
      if (out_valid === 1'b1) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.payload_addr !== want.payload_addr) begin
            $error("payload_addr: expected %0d, got %0d",
                   want.payload_addr, out_data.payload_addr);
            fail_count++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
            fail_count++;
          end
        end
      end
    end
    n_pending <= expected_q.size();
  end

endmodule

/* tb/tb.sv */
// Top of the allocator testbench: clock, reset, request and limit-write
// stimulus, and the verdict. Depends on ffba_pkg, the allocator top level
// and ffba_checker, which does all prediction and comparison.
module tb;
  import ffba_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  in_t               in_data = '0;
  logic              cfg_valid = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              busy;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_ready;

  int fail_count;
  int n_pending;
  int n_checked;
  int n_limits = 0;
  bit gaps_on = 1'b1;

  int limit_set [6] = '{2097151, 0, 300, 1048577, 5000, 1048576};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_fit_block_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ffba_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .n_pending  (n_pending),
    .n_checked  (n_checked)
  );

  // Start stays high across back-to-back transactions; it drops for gaps and in wait_quiet.
  task automatic send_txn(input logic op, input logic [SIZE_W-1:0] sz,
                          input logic [SLOT_W-1:0] idx);
    in_t t;
    t.opcode = op;
    t.req_size = sz;
    t.block_index = idx;
    while (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The unused field of each request carries random bits.
  task automatic alloc_bytes(input logic [SIZE_W-1:0] sz);
    send_txn(OP_ALLOC, sz, SLOT_W'($urandom));
  endtask

  task automatic free_slot(input logic [SLOT_W-1:0] idx);
    send_txn(OP_FREE, SIZE_W'($urandom), idx);
  endtask

  // Freeing from the top slot down releases every block, whatever its mark.
  task automatic release_all();
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) free_slot(SLOT_W'(i));
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0 || busy) @(posedge clk);
  endtask

  task automatic set_limit(input logic [SIZE_W-1:0] v);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  task automatic random_txn(input int alloc_pct);
    logic [SIZE_W-1:0] sz;
    if ($urandom_range(99) < alloc_pct) begin
      case ($urandom_range(9))
        0:       sz = SIZE_W'($urandom);
        1:       sz = $urandom_range(1) ? SIZE_W'(0) : HEAP_CEILING;
        2, 3:    sz = SIZE_W'($urandom_range(2000, 1));
        default: sz = SIZE_W'($urandom_range(64, 1));
      endcase
      alloc_bytes(sz);
    end else begin
      free_slot(SLOT_W'($urandom_range(9) < 8 ? $urandom_range(15) : $urandom_range(63)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset limit.
    alloc_bytes('0);
    free_slot('0);
    free_slot(SLOT_W'(63));
    alloc_bytes(SIZE_W'(1));
    alloc_bytes(HEAP_CEILING);
    alloc_bytes(HEAP_CEILING - SIZE_W'(33));  // fills the heap exactly
    alloc_bytes(SIZE_W'(1));
    free_slot(SLOT_W'(1));
    alloc_bytes(SIZE_W'(100));
    alloc_bytes(SIZE_W'(50));
    alloc_bytes(SIZE_W'(10));
    free_slot(SLOT_W'(1));
    free_slot(SLOT_W'(1));
    alloc_bytes(SIZE_W'(60));
    free_slot(SLOT_W'(2));
    free_slot(SLOT_W'(3));
    free_slot(SLOT_W'(2));  // top block that was already marked free
    alloc_bytes({SIZE_W{1'b1}});
    free_slot(SLOT_W'(5));
    release_all();

    for (int p = 0; p < 6; p++) begin
      set_limit(SIZE_W'(limit_set[p]));
      gaps_on = (p != 3);
      // Small blocks fill the whole table so the full-table path is reached.
      if (p == 0) repeat (MAX_BLOCKS + 2) alloc_bytes(SIZE_W'($urandom_range(8, 1)));
      repeat (55) random_txn(60 + 5 * p);
      release_all();
    end
    set_limit(HEAP_CEILING);

    wait_quiet();
    repeat (MAX_BLOCKS + 4) @(posedge clk);
    $display("Checked %0d allocate/free transactions under %0d heap limit settings,",
             n_checked, n_limits);
    $display("including zero size, heap limit, full table and bad index outcomes.");
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
